FILE: rtl/mbs_pkg.sv
`default_nettype none
package mbs_pkg;

  typedef enum logic [2:0] {
    EV_STARTED  = 3'd0,
    EV_CARVED   = 3'd1,
    EV_BACK     = 3'd2,
    EV_FINISHED = 3'd3,
    EV_IDLE     = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  localparam logic [1:0] CFG_ROWS  = 2'd0;
  localparam logic [1:0] CFG_COLS  = 2'd1;
  localparam logic [1:0] CFG_SROW  = 2'd2;
  localparam logic [1:0] CFG_SCOL  = 2'd3;

  typedef struct packed {
    logic       start;
    logic [1:0] rnd;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/mbs_ram.sv
`default_nettype none
module mbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/mbs_front.sv
`default_nettype none
// Two-entry command queue between the input channel and the step engine.
module mbs_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         in_op,
  input  wire logic [1:0]   in_rnd,
  output logic              cmd_valid,
  output mbs_pkg::cmd_t     cmd,
  input  wire logic         cmd_take
);

  mbs_pkg::cmd_t q_r [2];
  logic          rd_r, wr_r;
  logic [1:0]    cnt_r;
  logic          push;
  logic          pop;

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];
  assign pop       = cmd_valid && cmd_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      q_r[wr_r].start <= ~in_op;
      q_r[wr_r].rnd   <= in_rnd;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mbs_back.sv
`default_nettype none
// Step engine: visited map with epoch marks, path stack, output register.
module mbs_back #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cmd_valid,
  input  wire mbs_pkg::cmd_t cmd,
  output logic              cmd_take,
  input  wire logic [6:0]   rows_cfg,
  input  wire logic [6:0]   cols_cfg,
  input  wire logic [5:0]   srow_cfg,
  input  wire logic [5:0]   scol_cfg,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [2:0]        out_event_res,
  output logic [5:0]        out_row,
  output logic [5:0]        out_col,
  output logic [1:0]        out_dir
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int DEPTH = 1 << AW;
  localparam int EW    = 8;
  localparam int SCW   = AW + 1;

  typedef enum logic [2:0] {S_IDLE, S_PROBE, S_WAIT, S_CHECK, S_POP, S_POPW, S_OUT} st_t;

  st_t              st_r;
  logic [EW-1:0]    epoch_r;
  logic [SCW-1:0]   sp_r;
  logic [RW-1:0]    crow_r, nrow_r;
  logic [CW-1:0]    ccol_r, ncol_r;
  logic             run_r;
  logic [1:0]       k_r, d_r, rnd_r;
  logic             inb_r;
  logic [2:0]       ev_r;
  logic [1:0]       odir_r;

  logic [RW:0]      urows;
  logic [CW:0]      ucols;
  logic [RW-1:0]    trow;
  logic [CW-1:0]    tcol;
  logic             tok;
  logic             tin;
  logic [1:0]       dcur;

  logic             vwe;
  logic [AW-1:0]    vwaddr, vraddr;
  logic [EW-1:0]    vwdata;
  logic [EW-1:0]    vrdata;
  logic             swe;
  logic [AW-1:0]    swaddr, sraddr;
  logic [AW-1:0]    srdata;

  always_comb begin
    if (rows_cfg == 7'd0) urows = (RW+1)'(1);
    else if (32'(rows_cfg) > MAX_ROWS) urows = (RW+1)'(MAX_ROWS);
    else urows = (RW+1)'(rows_cfg);
    if (cols_cfg == 7'd0) ucols = (CW+1)'(1);
    else if (32'(cols_cfg) > MAX_COLS) ucols = (CW+1)'(MAX_COLS);
    else ucols = (CW+1)'(cols_cfg);
  end

  assign dcur = rnd_r + k_r;

  always_comb begin
    trow = crow_r;
    tcol = ccol_r;
    tok  = 1'b1;
    unique case (mbs_pkg::dir_t'(dcur))
      mbs_pkg::DIR_N: begin
        tok  = (crow_r != '0);
        trow = crow_r - 1'b1;
      end
      mbs_pkg::DIR_E: begin
        tok  = ({1'b0, ccol_r} + 1'b1) < ucols;
        tcol = ccol_r + 1'b1;
      end
      mbs_pkg::DIR_S: begin
        tok  = ({1'b0, crow_r} + 1'b1) < urows;
        trow = crow_r + 1'b1;
      end
      mbs_pkg::DIR_W: begin
        tok  = (ccol_r != '0);
        tcol = ccol_r - 1'b1;
      end
      default: tok = 1'b0;
    endcase
    tin = tok && ({1'b0, trow} < urows) && ({1'b0, tcol} < ucols);
  end

  assign vraddr = {trow, tcol};
  assign sraddr = AW'(sp_r - 1'b1);

  mbs_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_visited (
    .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata),
    .raddr(vraddr), .rdata(vrdata)
  );

  mbs_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_stack (
    .clk(clk), .we(swe), .waddr(swaddr), .wdata({crow_r, ccol_r}),
    .raddr(sraddr), .rdata(srdata)
  );

  logic [RW-1:0] srow_sat;
  logic [CW-1:0] scol_sat;
  logic          clr_r;
  logic [AW-1:0] clr_a_r;
  logic          need_clr;

  always_comb begin
    srow_sat = ({1'b0, srow_cfg} < 7'(urows)) ? RW'(srow_cfg) : RW'(urows - 1'b1);
    scol_sat = ({1'b0, scol_cfg} < 7'(ucols)) ? CW'(scol_cfg) : CW'(ucols - 1'b1);
  end

  assign need_clr = (st_r == S_IDLE) && cmd_valid && cmd.start && !clr_r &&
                    (epoch_r == '1);
  assign cmd_take = (st_r == S_IDLE) && cmd_valid && !clr_r && !need_clr;

  always_comb begin
    vwe    = 1'b0;
    vwaddr = {nrow_r, ncol_r};
    vwdata = epoch_r;
    swe    = 1'b0;
    swaddr = AW'(sp_r);
    if (clr_r) begin
      vwe    = 1'b1;
      vwaddr = clr_a_r;
      vwdata = '0;
    end else if (st_r == S_CHECK && inb_r && vrdata != epoch_r) begin
      vwe = 1'b1;
      swe = (sp_r < SCW'(CELLS));
    end else if (cmd_take && cmd.start) begin
      vwe    = 1'b1;
      vwaddr = {srow_sat, scol_sat};
      vwdata = epoch_r + 1'b1;
    end
  end

  assign out_valid     = (st_r == S_OUT);
  assign out_event_res = ev_r;
  assign out_row       = 6'(crow_r);
  assign out_col       = 6'(ccol_r);
  assign out_dir       = odir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      epoch_r <= '0;
      sp_r    <= '0;
      crow_r  <= '0;
      ccol_r  <= '0;
      run_r   <= 1'b0;
      clr_r   <= 1'b1;
      clr_a_r <= '0;
    end else begin
      if (clr_r) begin
        clr_a_r <= clr_a_r + 1'b1;
        if (clr_a_r == '1) clr_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (cmd_take) begin
            rnd_r  <= cmd.rnd;
            k_r    <= 2'd0;
            odir_r <= 2'd0;
            if (cmd.start) begin
              crow_r <= srow_sat;
              ccol_r <= scol_sat;
              sp_r   <= '0;
              run_r  <= 1'b1;
              ev_r   <= mbs_pkg::EV_STARTED;
              st_r   <= S_OUT;
            end else if (!run_r) begin
              ev_r <= mbs_pkg::EV_IDLE;
              st_r <= S_OUT;
            end else begin
              st_r <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          nrow_r <= trow;
          ncol_r <= tcol;
          inb_r  <= tin;
          d_r    <= dcur;
          st_r   <= S_WAIT;
        end
        S_WAIT: st_r <= S_CHECK;
        S_CHECK: begin
          if (inb_r && vrdata != epoch_r) begin
            if (sp_r < SCW'(CELLS)) sp_r <= sp_r + 1'b1;
            crow_r <= nrow_r;
            ccol_r <= ncol_r;
            odir_r <= d_r;
            ev_r   <= mbs_pkg::EV_CARVED;
            st_r   <= S_OUT;
          end else if (k_r != 2'd3) begin
            k_r  <= k_r + 1'b1;
            st_r <= S_PROBE;
          end else if (sp_r == '0) begin
            run_r <= 1'b0;
            ev_r  <= mbs_pkg::EV_FINISHED;
            st_r  <= S_OUT;
          end else begin
            st_r <= S_POP;
          end
        end
        S_POP: st_r <= S_POPW;
        S_POPW: begin
          sp_r   <= sp_r - 1'b1;
          crow_r <= srdata[AW-1:CW];
          ccol_r <= srdata[CW-1:0];
          if (sp_r == SCW'(1)) begin
            run_r <= 1'b0;
            ev_r  <= mbs_pkg::EV_FINISHED;
          end else begin
            ev_r <= mbs_pkg::EV_BACK;
          end
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
      if (cmd_take && cmd.start) begin
        epoch_r <= epoch_r + 1'b1;
      end else if (need_clr) begin
        epoch_r <= '0;
        clr_r   <= 1'b1;
        clr_a_r <= '0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/maze_backtracker_step.sv
`default_nettype none
// A start or an idle step goes straight to output; a step probes neighbours in turn
// (probe, wait, check) and may pop the path stack (pop, pop-wait). Words run one at
// a time: none is taken until the last result has been taken. After reset, and before
// the start that follows each run of 255 starts, a pass over all 4096 entries (default
// sizes) clears the visited map; words are queued but not taken meanwhile.
// Reset is synchronous and active low; registers return to 50, 50, 25, 25.
module maze_backtracker_step #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_op,
  input  wire logic [1:0] in_rnd,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_event_res,
  output logic [5:0]      out_row,
  output logic [5:0]      out_col,
  output logic [1:0]      out_dir,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data
);

  logic [6:0]    rows_r, cols_r;
  logic [5:0]    srow_r, scol_r;
  logic          cmd_valid, cmd_take;
  mbs_pkg::cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 7'd50;
      cols_r <= 7'd50;
      srow_r <= 6'd25;
      scol_r <= 6'd25;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbs_pkg::CFG_ROWS: rows_r <= cfg_data;
        mbs_pkg::CFG_COLS: cols_r <= cfg_data;
        mbs_pkg::CFG_SROW: srow_r <= cfg_data[5:0];
        mbs_pkg::CFG_SCOL: scol_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  mbs_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_rnd(in_rnd), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take)
  );

  mbs_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .rows_cfg(rows_r), .cols_cfg(cols_r),
    .srow_cfg(srow_r), .scol_cfg(scol_r), .out_valid(out_valid),
    .out_stall(out_stall), .out_event_res(out_event_res), .out_row(out_row),
    .out_col(out_col), .out_dir(out_dir)
  );

endmodule
`default_nettype wire
